FILE: rtl/core/bblur_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblur_pkg
// Shared widths, register indexes and constants for the 3x3 box blur stream.
// ----------------------------------------------------------------------------
package bblur_pkg;

  localparam int PIX_W        = 8;
  localparam int IMG_WIDTH_W  = 11;
  localparam int IMG_HEIGHT_W = 12;
  localparam int ROW_W        = 13;
  localparam int SUM_W        = 12;

  localparam int DEF_MAX_WIDTH = 1024;

  localparam logic [IMG_WIDTH_W-1:0]  IMG_WIDTH_RST  = 11'd512;
  localparam logic [IMG_HEIGHT_W-1:0] IMG_HEIGHT_RST = 12'd512;

  // configuration request
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

  // floor(s / 9) = (s * DIV9_MULT) >> DIV9_SHIFT for s < 2^SUM_W
  localparam int DIV9_MULT_W = 13;
  localparam int DIV9_SHIFT  = 16;
  localparam int PROD_W      = SUM_W + DIV9_MULT_W;
  localparam logic [DIV9_MULT_W-1:0] DIV9_MULT = 13'd7282;

endpackage

FILE: rtl/core/bblur_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblur_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bblur_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/box_blur_3x3_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_stream
// 3x3 mean blur over a raster-order stream of 8-bit grayscale pixels.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per pixel, in_tdata = pixel, in_tuser = drain flag.
//           Drain requests before the last pixel of a frame are taken and
//           dropped; after it, every request flushes one position.
//   out_* : one request per output pixel in raster order, out_tlast on the
//           last pixel of the frame. Interior pixels carry floor(sum / 9) of
//           their neighbourhood, border pixels are passed through unchanged.
//   cfg_* : index 0 = image width, index 1 = image height; a write restarts
//           the frame position. Write only while the block is idle.
// Outputs lag the input by image width + 1 requests; send width + 1 drain
// requests after the last pixel. One request is accepted per clock while
// the stages have room; its output passes stage 1, stage 2 and the result
// register. The line stores are one RAM with registered read, bypassed when a
// column is read in the same cycle as it is written (width 1, or a frame wrap).
// Reset returns width and height to 512 and the frame position to zero; the
// line stores are not cleared. A stalled receiver holds the result register,
// and the two stages in front of it keep accepting until they are full.
// ----------------------------------------------------------------------------
module box_blur_3x3_stream
  import bblur_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,   // [7:0] pixel_in
  input  logic                  in_tuser,   // [0] drain
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [PIX_W-1:0]      out_tdata,  // [7:0] pixel_out
  output logic                  out_tlast,  // frame_end
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int LINE_W = 2 * PIX_W;

  // configuration
  logic [IMG_WIDTH_W-1:0]  cfg_width_r;
  logic [IMG_HEIGHT_W-1:0] cfg_height_r;
  logic                    cfg_wr;

  logic [CW:0]             w_eff;
  logic [IMG_HEIGHT_W-1:0] h_eff;

  // frame position
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  // input decode
  logic             acc;
  logic             tail;
  logic             eff;
  logic             have;
  logic             border;
  logic             last;
  logic [CW:0]      col_inc;
  logic [ROW_W-1:0] cr;
  logic [ROW_W-1:0] h_ext;
  logic [PIX_W-1:0] bot;

  // stage 1
  logic             s1_v_r;
  logic [CW-1:0]    s1_col_r;
  logic [PIX_W-1:0] s1_bot_r;
  logic             s1_emit_r;
  logic             s1_border_r;
  logic             s1_last_r;
  logic             s1_adv;
  logic             s1_room;

  // line store
  logic [LINE_W-1:0] ram_rdata;
  logic [LINE_W-1:0] ram_wdata;
  logic [LINE_W-1:0] line_word;
  logic              byp_v_r;
  logic [LINE_W-1:0] byp_d_r;
  logic [PIX_W-1:0]  top;
  logic [PIX_W-1:0]  mid;

  // window: [row][0] older column, [row][1] newer column
  logic [PIX_W-1:0] win_r [3][2];
  logic [SUM_W-1:0] sum;

  // stage 2
  logic              s2_v_r;
  logic [SUM_W-1:0]  s2_sum_r;
  logic [PIX_W-1:0]  s2_ctr_r;
  logic              s2_border_r;
  logic              s2_last_r;
  logic              s2_adv;
  logic              s2_room;
  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0]  res_pix;

  // result register
  logic             out_v_r;
  logic [PIX_W-1:0] out_pix_r;
  logic             out_last_r;
  logic             out_room;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= IMG_WIDTH_RST;
      cfg_height_r <= IMG_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_IDX_WIDTH:  cfg_width_r  <= cfg_data[IMG_WIDTH_W-1:0];
        CFG_IDX_HEIGHT: cfg_height_r <= cfg_data[IMG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_width_r == '0) begin
      w_eff = (CW+1)'(1);
    end else if (32'(cfg_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(cfg_width_r);
    end
    h_eff = (cfg_height_r == '0) ? IMG_HEIGHT_W'(1) : cfg_height_r;
  end

  // --------------------------------------------------------------------------
  // handshake
  // --------------------------------------------------------------------------
  assign out_room  = !out_v_r || out_tready;
  assign s2_room   = !s2_v_r || out_room;
  assign s2_adv    = s2_v_r && out_room;
  assign s1_room   = !s1_v_r || s2_room;
  assign s1_adv    = s1_v_r && s2_room;
  assign in_tready = s1_room;
  assign acc       = in_tvalid && in_tready;

  // --------------------------------------------------------------------------
  // input decode and frame position
  // --------------------------------------------------------------------------
  always_comb begin
    h_ext   = ROW_W'(h_eff);
    tail    = row_r >= h_ext;
    eff     = !(in_tuser && !tail);
    bot     = tail ? '0 : in_tdata;
    col_inc = {1'b0, col_r} + (CW+1)'(1);
    cr      = row_r - ((col_r == '0) ? ROW_W'(2) : ROW_W'(1));
    have    = (row_r >= ROW_W'(2)) || ((row_r == ROW_W'(1)) && (col_r != '0));
    border  = (col_r == '0) || (col_r == CW'(1)) || (cr == '0)
              || (cr == h_ext - ROW_W'(1));
    last    = (col_r == '0) && (row_r == h_ext + ROW_W'(1));

    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (acc && eff) begin
      if (have && last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_inc >= w_eff) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: line store read
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (acc) begin
      s1_v_r <= eff;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_col_r    <= col_r;
      s1_bot_r    <= bot;
      s1_emit_r   <= have;
      s1_border_r <= border;
      s1_last_r   <= last;
    end
  end

  assign ram_wdata = {s1_bot_r, mid};

  bblur_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (ram_wdata),
    .rd_en   (acc && eff),
    .rd_addr (col_r),
    .rd_data (ram_rdata)
  );

  // forward a column written in the same cycle as its read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_v_r <= 1'b0;
    end else if (acc && eff) begin
      byp_v_r <= s1_adv && (s1_col_r == col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (acc && eff) begin
      byp_d_r <= ram_wdata;
    end
  end

  assign line_word = byp_v_r ? byp_d_r : ram_rdata;
  assign mid       = line_word[LINE_W-1:PIX_W];
  assign top       = line_word[PIX_W-1:0];

  // --------------------------------------------------------------------------
  // window and sum
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
      end
      win_r[0][1] <= top;
      win_r[1][1] <= mid;
      win_r[2][1] <= s1_bot_r;
    end
  end

  always_comb begin
    sum = SUM_W'(top) + SUM_W'(mid) + SUM_W'(s1_bot_r);
    for (int r = 0; r < 3; r++) begin
      sum = sum + SUM_W'(win_r[r][0]) + SUM_W'(win_r[r][1]);
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: divide by nine
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s1_adv && s1_emit_r) begin
      s2_v_r <= 1'b1;
    end else if (s2_adv) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit_r) begin
      s2_sum_r    <= sum;
      s2_ctr_r    <= win_r[1][1];
      s2_border_r <= s1_border_r;
      s2_last_r   <= s1_last_r;
    end
  end

  assign prod    = PROD_W'(s2_sum_r) * PROD_W'(DIV9_MULT);
  assign res_pix = s2_border_r ? s2_ctr_r : prod[DIV9_SHIFT +: PIX_W];

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s2_adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_pix_r  <= res_pix;
      out_last_r <= s2_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: test/box_blur_3x3_stream_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_stream_test
// Self-checking bench for the streamed 3x3 box blur. A cycle-free predictor
// follows every accepted pixel request and queues the expected output pixels;
// a monitor compares each output request against the oldest one. Directed
// frames cover saturated and alternating pixels, ignored and discarded drain
// requests, degenerate sizes and a restart in mid-frame; then come a wide
// frame and a very tall frame cut short, a long receiver hold-off, a stretch
// without idling and random frames with random idling on both sides.
// ----------------------------------------------------------------------------
module box_blur_3x3_stream_test;
  import bblur_pkg::*;

  localparam int MAX_W        = DEF_MAX_WIDTH;
  localparam int IDLE_PCT     = 18;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 12;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 200;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_end;
  } blurred_px_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata;   // [7:0] pixel_in
  logic                  in_tuser;   // [0] drain
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [PIX_W-1:0]      out_tdata;  // [7:0] pixel_out
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  box_blur_3x3_stream dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [IMG_WIDTH_W-1:0]  width_reg;
  logic [IMG_HEIGHT_W-1:0] height_reg;
  logic [PIX_W-1:0]        line_a [MAX_W];
  logic [PIX_W-1:0]        line_b [MAX_W];
  logic [PIX_W-1:0]        win [3][3];
  int unsigned             col_pos;
  int unsigned             row_pos;
  int unsigned             out_cnt;
  blurred_px_t             blurred_q [$];

  int unsigned pixels_taken;
  int unsigned results_seen;
  int unsigned frames_seen;
  int unsigned errors;
  int unsigned stall_cnt;
  int unsigned hold_asked;
  int unsigned hold_done;
  int unsigned hold_left;
  bit          quiet;

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic void restart_position();
    col_pos = 0;
    row_pos = 0;
    out_cnt = 0;
  endfunction

  function automatic void blur_step(input logic [PIX_W-1:0] px, input logic drain_flag);
    int unsigned w, h, col, cr, cc, sum;
    logic [PIX_W-1:0] top, mid, bot;
    bit tail, have;
    blurred_px_t res;
    w = eff_width();
    h = eff_height();
    tail = (row_pos >= h);
    if (drain_flag && !tail) return;
    pixels_taken++;
    bot = tail ? '0 : px;
    col = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
    top = line_b[col];
    mid = line_a[col];
    line_b[col] = mid;
    line_a[col] = bot;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = bot;
    if (col_pos == 0) begin
      cc = w - 1;
      cr = row_pos - 2;
    end else begin
      cc = col_pos - 1;
      cr = row_pos - 1;
    end
    have = (row_pos >= 2) || (row_pos == 1 && col_pos >= 1);
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (!have) return;
    if (cr == 0 || cr == h - 1 || cc == 0 || cc == w - 1) begin
      res.pixel = win[1][1];
    end else begin
      sum = 0;
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++)
          sum += win[a][b];
      res.pixel = PIX_W'(sum / 9);
    end
    res.frame_end = (out_cnt >= h * w - 1);
    if (res.frame_end) restart_position();
    else out_cnt++;
    blurred_q.push_back(res);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 20) $display("mismatch at %0t ns: %s got %0d want %0d", $time, what, got, want);
  endtask

  task automatic send_item(input logic [PIX_W-1:0] px, input logic drain_flag);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    in_tuser  <= drain_flag;
    do @(posedge clk); while (!in_tready);
    blur_step(px, drain_flag);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (blurred_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_IDX_WIDTH) width_reg = value[IMG_WIDTH_W-1:0];
    else if (idx == CFG_IDX_HEIGHT) height_reg = value[IMG_HEIGHT_W-1:0];
    restart_position();
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h);
    wait_idle();
    write_reg(CFG_IDX_WIDTH, w);
    write_reg(CFG_IDX_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // cut < 0 sends the whole frame and its tail, otherwise only cut pixels
  task automatic send_frame(input int noise_pct, input int tail_data_pct, input int cut);
    int unsigned total;
    total = (cut < 0) ? eff_width() * eff_height() : cut;
    for (int unsigned i = 0; i < total; i++) begin
      if ($urandom_range(99) < noise_pct) send_item(rand_pixel(), 1'b1);
      send_item(rand_pixel(), 1'b0);
    end
    if (cut < 0)
      for (int unsigned i = 0; i <= eff_width(); i++)
        send_item(rand_pixel(), $urandom_range(99) >= tail_data_pct);
  endtask

  task automatic test_extremes();
    set_frame(3, 3);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_item(8'hA5, 1'b1);
      send_item(8'hFF, 1'b0);
    end
    for (int i = 0; i < 4; i++) send_item(8'h5A, i[0]);
    for (int i = 0; i < 9; i++) send_item(i[0] ? 8'hFF : 8'h00, 1'b0);
    for (int i = 0; i < 4; i++) send_item(8'h00, 1'b1);
  endtask

  task automatic test_tiny_frames();
    set_frame(0, 0);
    send_frame(0, 50, -1);
    set_frame(1, 3);
    send_frame(0, 50, -1);
  endtask

  task automatic test_restart_mid_frame();
    set_frame(4, 3);
    send_frame(0, 0, 6);
    wait_idle();
    write_reg(CFG_IDX_HEIGHT, 2);
    cfg_valid <= 1'b0;
    send_frame(0, 30, -1);
  endtask

  task automatic test_large_sizes();
    set_frame(64, 2);
    send_frame(2, 30, -1);
    set_frame(1, 4095);
    send_frame(2, 30, 40);
  endtask

  task automatic test_backpressure();
    set_frame(24, 6);
    hold_asked++;
    send_frame(0, 30, -1);
  endtask

  task automatic test_no_idle();
    quiet = 1'b1;
    set_frame(16, 8);
    send_frame(5, 30, -1);
    wait_idle();
    quiet = 1'b0;
  endtask

  task automatic test_random_frames();
    int unsigned start, w, h;
    start = pixels_taken;
    while (pixels_taken - start < RANDOM_ITEMS) begin
      case ($urandom_range(19))
        0:             w = $urandom_range(80, 41);
        1, 2, 3, 4, 5: w = $urandom_range(40, 9);
        default:       w = $urandom_range(8, 1);
      endcase
      if (w > 40) h = $urandom_range(2, 1);
      else if ($urandom_range(19) == 0) h = $urandom_range(30, 11);
      else h = $urandom_range(10, 1);
      set_frame(w, h);
      if ($urandom_range(99) < 15) send_frame(5, 30, $urandom_range(w * h - 1, 0));
      else send_frame(5, 30, -1);
    end
  endtask

  // receiver readiness, with an occasional long hold-off
  always @(posedge clk) begin
    if (hold_asked != hold_done) begin
      hold_done++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    blurred_px_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tlast) frames_seen++;
      if (blurred_q.size() == 0) begin
        report_mismatch("unexpected pixel", out_tdata, -1);
      end else begin
        want = blurred_q.pop_front();
        if (out_tdata !== want.pixel) report_mismatch("pixel_out", out_tdata, want.pixel);
        if (out_tlast !== want.frame_end)
          report_mismatch("frame_end", out_tlast, want.frame_end);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    width_reg  = IMG_WIDTH_RST;
    height_reg = IMG_HEIGHT_RST;
    for (int i = 0; i < MAX_W; i++) begin
      line_a[i] = '0;
      line_b[i] = '0;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        win[r][c] = '0;
    restart_position();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_tiny_frames();
    test_restart_mid_frame();
    test_large_sizes();
    test_backpressure();
    test_no_idle();
    test_random_frames();
    wait_idle();

    if (blurred_q.size() != 0) report_mismatch("results missing", 0, blurred_q.size());
    $display("covered %0d pixel requests, %0d output pixels and %0d complete frames",
             pixels_taken, results_seen, frames_seen);
    $display("sizes from 1x1 to 80 wide, a 4095 high frame cut short, hold-off and idling");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/bblur_pkg.sv
rtl/core/bblur_ram.sv
rtl/core/box_blur_3x3_stream.sv
test/box_blur_3x3_stream_test.sv
